// ===== rtl/core/qbo_pkg.sv =====
// ----------------------------------------------------------------------------
// qbo_pkg
// Shared types, widths, register codes and helpers for the Q15 biquad
// oscillator.
// ----------------------------------------------------------------------------
package qbo_pkg;

    localparam int SampleW = 16;
    localparam int ProdW   = 2 * SampleW;
    // five 32-bit products plus the rounding bias
    localparam int AccW    = ProdW + 3;
    localparam int FracW   = 15;
    localparam int HalfW   = AccW - FracW;
    localparam int IdxW    = 3;

    typedef logic signed [SampleW-1:0] sample_t;
    typedef logic [IdxW-1:0] cfg_idx_t;

    // register indexes on the configuration port
    localparam cfg_idx_t RegFeedbackFirst  = 3'd0;
    localparam cfg_idx_t RegFeedbackSecond = 3'd1;
    localparam cfg_idx_t RegInputNow       = 3'd2;
    localparam cfg_idx_t RegInputFirst     = 3'd3;
    localparam cfg_idx_t RegInputSecond    = 3'd4;

    localparam sample_t ResetFeedbackFirst  = 16'sd32508;
    localparam sample_t ResetFeedbackSecond = -16'sd16384;
    localparam sample_t ResetInputNow       = 16'sd1026;
    localparam sample_t ResetInputFirst     = 16'sd2051;
    localparam sample_t ResetInputSecond    = 16'sd1026;

    localparam sample_t Q15Max = 16'sh7fff;
    localparam sample_t Q15Min = 16'sh8000;

    localparam logic signed [AccW-1:0] RoundBias = AccW'(1 << (FracW - 1));

    typedef struct packed {
        sample_t feedback_first;
        sample_t feedback_second;
        sample_t input_now;
        sample_t input_first;
        sample_t input_second;
    } coef_set_t;

    // clamp a wide rounded value to Q15
    function automatic sample_t sat_q15(logic signed [HalfW-1:0] v);
        sample_t r;
        if (v > HalfW'(Q15Max))
            r = Q15Max;
        else if (v < HalfW'(Q15Min))
            r = Q15Min;
        else
            r = v[SampleW-1:0];
        return r;
    endfunction

    // double with saturation
    function automatic sample_t double_q15(sample_t v);
        sample_t r;
        if (v > (Q15Max >>> 1))
            r = Q15Max;
        else if (v < (Q15Min >>> 1))
            r = Q15Min;
        else
            r = v <<< 1;
        return r;
    endfunction

endpackage

// ===== rtl/core/qbo_coef_regs.sv =====
// ----------------------------------------------------------------------------
// qbo_coef_regs
// Coefficient register bank written through the plain configuration port.
// ----------------------------------------------------------------------------
module qbo_coef_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  qbo_pkg::cfg_idx_t cfg_index,
    input  qbo_pkg::sample_t  cfg_data,
    output qbo_pkg::coef_set_t coefs
);
    import qbo_pkg::*;

    coef_set_t coef_reg;
    coef_set_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                RegFeedbackFirst:  coef_next.feedback_first  = cfg_data;
                RegFeedbackSecond: coef_next.feedback_second = cfg_data;
                RegInputNow:       coef_next.input_now       = cfg_data;
                RegInputFirst:     coef_next.input_first     = cfg_data;
                RegInputSecond:    coef_next.input_second    = cfg_data;
                // drop writes beyond the last register
                default:           coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.feedback_first  <= ResetFeedbackFirst;
            coef_reg.feedback_second <= ResetFeedbackSecond;
            coef_reg.input_now       <= ResetInputNow;
            coef_reg.input_first     <= ResetInputFirst;
            coef_reg.input_second    <= ResetInputSecond;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

`ifndef ASSERT_OFF
    a_no_write_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr_en |=> $stable(coef_reg))
        else $error("coefficients changed without a write");
    a_bad_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr_en && cfg_index > RegInputSecond) |=> $stable(coef_reg))
        else $error("write beyond last register changed a coefficient");
`endif

endmodule

// ===== rtl/core/qbo_datapath.sv =====
// ----------------------------------------------------------------------------
// qbo_datapath
// Five-tap multiply-accumulate, round to nearest, saturate and double, with
// the input and output delay registers of the section.
// ----------------------------------------------------------------------------
module qbo_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  qbo_pkg::sample_t   x,
    input  qbo_pkg::coef_set_t coefs,
    output qbo_pkg::sample_t   y
);
    import qbo_pkg::*;

    sample_t y1_reg;
    sample_t y2_reg;
    sample_t x1_reg;
    sample_t x2_reg;

    logic signed [ProdW-1:0] p0;
    logic signed [ProdW-1:0] p1;
    logic signed [ProdW-1:0] p2;
    logic signed [ProdW-1:0] p3;
    logic signed [ProdW-1:0] p4;
    logic signed [AccW-1:0]  acc;
    logic signed [AccW-1:0]  rnd;
    sample_t                 half;

    always_comb
    begin
        p0   = coefs.feedback_first  * y1_reg;
        p1   = coefs.feedback_second * y2_reg;
        p2   = coefs.input_now       * x;
        p3   = coefs.input_first     * x1_reg;
        p4   = coefs.input_second    * x2_reg;
        acc  = AccW'(p0) + AccW'(p1) + AccW'(p2) + AccW'(p3) + AccW'(p4);
        // add half an LSB, then floor by dropping the fraction bits
        rnd  = acc + RoundBias;
        half = sat_q15(rnd[AccW-1:FracW]);
        y    = double_q15(half);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg <= '0;
            y2_reg <= '0;
            x1_reg <= '0;
            x2_reg <= '0;
        end
        else if (advance)
        begin
            y2_reg <= y1_reg;
            y1_reg <= y;
            x2_reg <= x1_reg;
            x1_reg <= x;
        end
    end

`ifndef ASSERT_OFF
    a_out_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (y2_reg == $past(y1_reg)) && (y1_reg == $past(y)))
        else $error("output delay line did not shift");
    a_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (x2_reg == $past(x1_reg)) && (x1_reg == $past(x)))
        else $error("input delay line did not shift");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(y1_reg) && $stable(x1_reg))
        else $error("delay line moved without an item");
    a_doubled: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (y[0] == 1'b0 || y == Q15Max))
        else $error("odd result that is not positive saturation");
`endif

endmodule

// ===== rtl/core/q15_biquad_oscillator.sv =====
// ----------------------------------------------------------------------------
// q15_biquad_oscillator
// Second-order IIR section in Q15 with half-scale coefficients and a doubled,
// saturated output. Input register, one pass of arithmetic, result register.
// ----------------------------------------------------------------------------
// Flow: an accepted item is held in the input register, and its result is
// registered in the result register when that register is free or emptying.
// Throughput: one item per cycle while the output is not stalled; the output
// delay loop closes combinationally through the five-multiply sum.
// Reset: delay line cleared to zero, coefficients return to their defaults,
// both stages empty.
module q15_biquad_oscillator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  qbo_pkg::cfg_idx_t cfg_index,
    input  qbo_pkg::sample_t  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  qbo_pkg::sample_t  sample_in,
    output logic              out_valid,
    input  logic              out_stall,
    output qbo_pkg::sample_t  sample_out
);
    import qbo_pkg::*;

    coef_set_t coefs;
    sample_t   y;

    logic      in_full_reg;
    logic      in_full_next;
    sample_t   x_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    sample_t   sample_out_reg;
    logic      accept;
    logic      advance;

    qbo_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    qbo_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .x       (x_reg),
        .coefs   (coefs),
        .y       (y)
    );

    // move the held item on whenever the result register is free or emptying
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_full_next   = accept || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            x_reg <= sample_in;
        if (advance)
            sample_out_reg <= y;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

`ifndef ASSERT_OFF
    a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with the result register empty");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(sample_out_reg))
        else $error("stalled result was overwritten or lost");
    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !advance) |=> in_full_reg && $stable(x_reg))
        else $error("held item dropped before it advanced");
`endif

endmodule

// ===== tb/sv/biquad_output_checker.sv =====
// ----------------------------------------------------------------------------
// biquad_output_checker
// Watches the configuration port and both sample channels of the Q15 biquad
// oscillator. It keeps its own copy of the gains and the delay line, predicts
// each output sample and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module biquad_output_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  qbo_pkg::cfg_idx_t cfg_index,
    input  qbo_pkg::sample_t  cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  qbo_pkg::sample_t  sample_in,
    input  logic              out_valid,
    input  logic              out_stall,
    input  qbo_pkg::sample_t  sample_out,
    output int                errors,
    output int                pending
);
    import qbo_pkg::*;

    localparam longint RoundHalf = 64'sd16384;

    coef_set_t gains;
    sample_t   out_z1;
    sample_t   out_z2;
    sample_t   in_z1;
    sample_t   in_z2;
    sample_t   expected_out[$];
    sample_t   next_y;
    sample_t   want;

    function automatic sample_t clamp_q15(longint v);
        sample_t r;
        if (v > longint'(Q15Max))
            r = Q15Max;
        else if (v < longint'(Q15Min))
            r = Q15Min;
        else
            r = sample_t'(v);
        return r;
    endfunction

    // Q30 sum, round to nearest (ties up), clamp, then double with clamp
    function automatic sample_t biquad_next_sample(coef_set_t g, sample_t y1, sample_t y2,
                                                   sample_t x1, sample_t x2, sample_t x);
        longint acc;
        longint half;
        acc = longint'(g.feedback_first)  * longint'(y1)
            + longint'(g.feedback_second) * longint'(y2)
            + longint'(g.input_now)       * longint'(x)
            + longint'(g.input_first)     * longint'(x1)
            + longint'(g.input_second)    * longint'(x2);
        half = (acc + RoundHalf) >>> 15;
        return clamp_q15(2 * longint'(clamp_q15(half)));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains.feedback_first  = ResetFeedbackFirst;
            gains.feedback_second = ResetFeedbackSecond;
            gains.input_now       = ResetInputNow;
            gains.input_first     = ResetInputFirst;
            gains.input_second    = ResetInputSecond;
            out_z1 = '0;
            out_z2 = '0;
            in_z1  = '0;
            in_z2  = '0;
            expected_out.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en === 1'b1)
            begin
                case (cfg_index)
                    RegFeedbackFirst:  gains.feedback_first  = cfg_data;
                    RegFeedbackSecond: gains.feedback_second = cfg_data;
                    RegInputNow:       gains.input_now       = cfg_data;
                    RegInputFirst:     gains.input_first     = cfg_data;
                    RegInputSecond:    gains.input_second    = cfg_data;
                    default: ;
                endcase
            end

            // retire before predicting: a result never belongs to this edge's item
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_out.size() == 0)
                begin
                    errors++;
                    $display("%0t: sample_out with no item waiting, expected none, got %0d",
                             $time, sample_out);
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (sample_out !== want)
                    begin
                        errors++;
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, want, sample_out);
                    end
                end
            end

            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                next_y = biquad_next_sample(gains, out_z1, out_z2, in_z1, in_z2, sample_in);
                expected_out.push_back(next_y);
                out_z2 = out_z1;
                out_z1 = next_y;
                in_z2  = in_z1;
                in_z1  = sample_in;
            end

            pending = expected_out.size();
        end
    end

endmodule

// ===== tb/sv/tb_q15_biquad_oscillator.sv =====
// ----------------------------------------------------------------------------
// tb_q15_biquad_oscillator
// Drives the Q15 biquad oscillator through several gain settings: a short
// directed run (impulse response, input and gain extremes), then phases of
// random samples and impulse bursts with random gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_q15_biquad_oscillator;
    import qbo_pkg::*;

    localparam int      NumPhases     = 10;
    localparam int      PhaseItems    = 43;
    localparam int      WatchdogLimit = 1000;
    localparam int      TailCycles    = 4;
    localparam sample_t ImpulseLevel  = 16'sd16384;

    logic     clk;
    logic     rst_n;
    logic     cfg_wr_en;
    cfg_idx_t cfg_index;
    sample_t  cfg_data;
    logic     in_valid;
    logic     in_stall;
    sample_t  sample_in;
    logic     out_valid;
    logic     out_stall;
    sample_t  sample_out;

    int errors;
    int pending;
    int in_calm;
    int out_calm = 0;
    int quiet_cycles = 0;

    q15_biquad_oscillator DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    biquad_output_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // most draws are zero, with occasional calm stretches of no idling
    function automatic int draw_gap(inout int calm_left);
        int gap;
        gap = 0;
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(8, 40);
        else if ($urandom_range(0, 1) == 1)
            gap = $urandom_range(0, 18);
        return gap;
    endfunction

    function automatic sample_t pick_sample();
        sample_t s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: s = sample_t'($urandom);
            4, 5:       s = sample_t'(int'($urandom_range(0, 1023)) - 512);
            6:          s = Q15Max;
            7:          s = Q15Min;
            8:          s = '0;
            default:    s = -16'sd1;
        endcase
        return s;
    endfunction

    task automatic send_sample(input sample_t s);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    // call in the step of an acceptance so the item is not taken twice
    task automatic stop_feed();
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input sample_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_gains(input sample_t g0, input sample_t g1, input sample_t g2,
                              input sample_t g3, input sample_t g4);
        write_reg(RegFeedbackFirst, g0);
        write_reg(RegFeedbackSecond, g1);
        write_reg(RegInputNow, g2);
        write_reg(RegInputFirst, g3);
        write_reg(RegInputSecond, g4);
        // an unmapped index must leave every gain alone
        write_reg(cfg_idx_t'(RegInputSecond + $urandom_range(1, 3)), sample_t'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // output side: stall for a random gap ahead of some results
    initial
    begin
        int gap;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(out_calm);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WatchdogLimit)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        sample_t g0, g1, g2, g3, g4;
        int      n;
        int      zeros;
        int      k;
        in_calm      = 0;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= RegFeedbackFirst;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        sample_in <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: impulse response of the oscillator, then input extremes
        send_sample(ImpulseLevel);
        repeat (7) send_sample('0);
        send_sample(Q15Max);
        send_sample(Q15Min);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample('0);
        stop_feed();
        wait_idle();

        // full-scale gains drive both rounding and doubling into saturation
        load_gains(Q15Max, Q15Max, Q15Max, Q15Max, Q15Max);
        repeat (3) send_sample(Q15Max);
        repeat (3) send_sample(Q15Min);
        stop_feed();
        wait_idle();
        load_gains(Q15Min, Q15Min, Q15Min, Q15Min, Q15Min);
        repeat (3) send_sample(Q15Min);
        repeat (3) send_sample(Q15Max);
        stop_feed();
        wait_idle();

        for (k = 0; k < NumPhases; k++)
        begin
            g0 = sample_t'($urandom);
            g1 = sample_t'($urandom);
            g2 = sample_t'($urandom);
            g3 = sample_t'($urandom);
            g4 = sample_t'($urandom);
            case (k)
                0, 9:
                begin
                    g0 = ResetFeedbackFirst;
                    g1 = ResetFeedbackSecond;
                    g2 = ResetInputNow;
                    g3 = ResetInputFirst;
                    g4 = ResetInputSecond;
                end
                1:
                begin
                    g0 = Q15Max;
                    g1 = Q15Min;
                end
                2:
                begin
                    g0 = Q15Min;
                    g1 = Q15Max;
                end
                3:
                begin
                    // stable-ish resonator with light input gains
                    g0 = sample_t'($urandom_range(0, 32767));
                    g1 = sample_t'(-int'($urandom_range(8192, 16384)));
                    g2 = sample_t'(int'($urandom_range(0, 4095)) - 2048);
                    g3 = sample_t'(int'($urandom_range(0, 4095)) - 2048);
                    g4 = sample_t'(int'($urandom_range(0, 4095)) - 2048);
                end
                4:
                begin
                    g2 = Q15Max;
                    g3 = Q15Min;
                    g4 = '0;
                end
                default: ;
            endcase
            load_gains(g0, g1, g2, g3, g4);

            n = 0;
            while (n < PhaseItems)
            begin
                case ($urandom_range(0, 19))
                    0:
                    begin
                        // hold off until the pipeline has emptied
                        stop_feed();
                        wait_idle();
                    end
                    1, 2, 3, 4:
                    begin
                        send_sample(($urandom_range(0, 2) == 0) ? pick_sample() : ImpulseLevel);
                        zeros = $urandom_range(4, 12);
                        repeat (zeros) send_sample('0);
                        n += zeros + 1;
                    end
                    default:
                    begin
                        send_sample(pick_sample());
                        n++;
                    end
                endcase
            end
            stop_feed();
            wait_idle();
        end

        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/qbo_pkg.sv
rtl/core/qbo_coef_regs.sv
rtl/core/qbo_datapath.sv
rtl/core/q15_biquad_oscillator.sv
tb/sv/biquad_output_checker.sv
tb/sv/tb_q15_biquad_oscillator.sv
